@@ rtl/pjr_pkg.sv @@
package pjr_pkg;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_FOCAL_X = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FOCAL_Y = 8'd1;

  localparam int FOCAL_W = 16;
  localparam logic [FOCAL_W-1:0] FOCAL_RESET = 16'd8192;

  // Field widths.
  localparam int GRAD_W  = 11;
  localparam int COORD_W = 24;
  localparam int JAC_W   = 48;

  // Quotient bits produced by the long divider; a larger quotient is held at 2^QUO_BITS.
  localparam int QUO_BITS = 48;

  // Divider shapes: numerator and denominator widths.
  localparam int NUM_W_P  = 54;  // |P| * 2^28
  localparam int NUM_W_N  = 79;  // |N| * 2^28
  localparam int NUM_W_NC = 87;  // |N * coord| * 2^12
  localparam int NUM_W_M  = 63;  // |Q*X - P*Y| * 2^12
  localparam int DEN_W_Z  = 23;  // Z
  localparam int DEN_W_ZZ = 46;  // Z^2

  typedef struct packed {
    logic [5:0]        neg;
    logic signed [26:0] p;
    logic signed [26:0] q;
    logic              inv;
    logic              last;
  } side_t;

endpackage

@@ rtl/pjr_divider.sv @@
module pjr_divider #(
  parameter int NUM_W = pjr_pkg::NUM_W_NC,
  parameter int DEN_W = pjr_pkg::DEN_W_ZZ
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [NUM_W-1:0]           num,
  input  logic [DEN_W-1:0]           den,
  output logic [pjr_pkg::QUO_BITS:0] quo
);

  localparam int QB   = pjr_pkg::QUO_BITS;
  localparam int HI_W = NUM_W - QB;
  localparam int CW   = (HI_W > DEN_W) ? HI_W : DEN_W;

  logic [DEN_W-1:0] rem [0:QB-1];
  logic [QB-1:0]    low [0:QB-1];
  logic [DEN_W-1:0] dv  [0:QB-1];
  logic [QB-1:0]    qv  [0:QB];
  logic             ov  [0:QB];

  logic [CW-1:0] hi_c;
  logic [CW-1:0] den_c;
  logic          ovf;

  assign hi_c  = CW'(num[NUM_W-1:QB]);
  assign den_c = CW'(den);
  assign ovf   = (hi_c >= den_c);

  // The first stage checks whether the quotient fits in QB bits at all.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= ovf ? '0 : DEN_W'(hi_c);
      low[0] <= num[QB-1:0];
      dv[0]  <= den;
      qv[0]  <= '0;
      ov[0]  <= ovf;
    end
  end

  // One restoring step, one quotient bit, per stage.
  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;

    assign trial = {rem[k-1], low[k-1][QB-1]};
    assign diff  = trial - {1'b0, dv[k-1]};
    assign ge    = (trial >= {1'b0, dv[k-1]});

    always_ff @(posedge clk) begin
      if (en) begin
        qv[k] <= {qv[k-1][QB-2:0], ge};
        ov[k] <= ov[k-1];
      end
    end

    if (k < QB) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
          low[k] <= low[k-1] << 1;
          dv[k]  <= dv[k-1];
        end
      end
    end
  end

  assign quo = ov[QB] ? {1'b1, QB'(0)} : {1'b0, qv[QB]};

endmodule

@@ rtl/photometric_jacobian_row.sv @@
// Channel   Direction  Contents
// s_*       in         request: gradient, point and last flag of one feature
// m_*       out        request: six Jacobian entries, depth and clamp flags, last flag
// cfg_*     in         register write: focal_x (index 0), focal_y (index 1)
//
// Every request passes through five stages of products and sums,
// 49 stages of the restoring dividers (an overflow check, then one quotient bit per stage),
// a sign and offset stage and the output register. One request is taken per cycle unless the pipeline holds.
// Reset (rst, synchronous) clears the valid bits and loads both focal lengths with 512.0.
// The whole pipeline moves together; it holds while the output register is full and
// m_tready is low, so a stall neither drops nor repeats anything.
module photometric_jacobian_row (
  input  logic         clk,
  input  logic         rst,
  // s_tdata fields from bit 0: grad_x[10:0], grad_y[10:0], point_x[23:0],
  // point_y[23:0], point_z[23:0], two zero bits.
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,
  input  logic         s_tlast,
  // m_tdata fields from bit 0: jac_tx, jac_ty, jac_tz, jac_rx, jac_ry, jac_rz (48 bits each).
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [287:0] m_tdata,
  // m_tuser fields from bit 0: depth_invalid, saturated.
  output logic [1:0]   m_tuser,
  output logic         m_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [pjr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pjr_pkg::FOCAL_W-1:0]     cfg_data
);

  localparam int QB      = pjr_pkg::QUO_BITS;
  localparam int DIV_LAT = QB + 1;

  // Focal length registers.
  logic [15:0] focal_x;
  logic [15:0] focal_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x <= pjr_pkg::FOCAL_RESET;
      focal_y <= pjr_pkg::FOCAL_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == pjr_pkg::REG_FOCAL_X) begin
        focal_x <= cfg_data;
      end else if (cfg_index == pjr_pkg::REG_FOCAL_Y) begin
        focal_y <= cfg_data;
      end
    end
  end

  // The pipeline advances as one whenever the output register is free or being emptied.
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Input fields.
  logic signed [10:0] grad_x;
  logic signed [10:0] grad_y;
  logic signed [23:0] point_x;
  logic signed [23:0] point_y;
  logic signed [23:0] point_z;

  assign grad_x  = s_tdata[10:0];
  assign grad_y  = s_tdata[21:11];
  assign point_x = s_tdata[45:22];
  assign point_y = s_tdata[69:46];
  assign point_z = s_tdata[93:70];

  // Valid bits of the stages around the dividers.
  logic vld1, vld2, vld3, vld4, vld5, vld6;
  logic dly_v [0:DIV_LAT-1];

  // Stage 1: gradient times focal length, and Z squared.
  logic signed [27:0] p_full;
  logic signed [27:0] q_full;
  assign p_full = grad_x * $signed({1'b0, focal_x});
  assign q_full = grad_y * $signed({1'b0, focal_y});

  logic signed [26:0] p1, q1;
  logic signed [23:0] x1, y1, z1;
  logic [45:0]        zz1;
  logic               inv1, last1;

  always_ff @(posedge clk) begin
    if (en) begin
      p1    <= p_full[26:0];
      q1    <= q_full[26:0];
      x1    <= point_x;
      y1    <= point_y;
      z1    <= point_z;
      zz1   <= point_z[22:0] * point_z[22:0];
      inv1  <= (point_z[23] || point_z == '0);
      last1 <= s_tlast;
    end
  end

  // Stage 2: the four cross products of P, Q with X, Y.
  logic signed [50:0] px2, qy2, qx2, py2;
  logic signed [26:0] p2, q2;
  logic signed [23:0] x2, y2, z2;
  logic [45:0]        zz2;
  logic               inv2, last2;

  always_ff @(posedge clk) begin
    if (en) begin
      px2   <= p1 * x1;
      qy2   <= q1 * y1;
      qx2   <= q1 * x1;
      py2   <= p1 * y1;
      p2    <= p1;
      q2    <= q1;
      x2    <= x1;
      y2    <= y1;
      z2    <= z1;
      zz2   <= zz1;
      inv2  <= inv1;
      last2 <= last1;
    end
  end

  // Stage 3: N = P*X + Q*Y and M = Q*X - P*Y.
  logic signed [51:0] n3, m3;
  logic signed [26:0] p3, q3;
  logic signed [23:0] x3, y3, z3;
  logic [45:0]        zz3;
  logic               inv3, last3;

  always_ff @(posedge clk) begin
    if (en) begin
      n3    <= 52'(px2) + 52'(qy2);
      m3    <= 52'(qx2) - 52'(py2);
      p3    <= p2;
      q3    <= q2;
      x3    <= x2;
      y3    <= y2;
      z3    <= z2;
      zz3   <= zz2;
      inv3  <= inv2;
      last3 <= last2;
    end
  end

  // Stage 4: magnitudes, and |N| times |X| and |Y| in two halves each.
  logic [50:0] nmag3, mmag3;
  logic [25:0] pmag3, qmag3;
  logic [23:0] xmag3, ymag3;

  assign nmag3 = n3[51] ? 51'($unsigned(-n3)) : 51'($unsigned(n3));
  assign mmag3 = m3[51] ? 51'($unsigned(-m3)) : 51'($unsigned(m3));
  assign pmag3 = p3[26] ? 26'($unsigned(-p3)) : 26'($unsigned(p3));
  assign qmag3 = q3[26] ? 26'($unsigned(-q3)) : 26'($unsigned(q3));
  assign xmag3 = x3[23] ? $unsigned(-x3) : $unsigned(x3);
  assign ymag3 = y3[23] ? $unsigned(-y3) : $unsigned(y3);

  logic [49:0]        nxl4, nyl4;
  logic [48:0]        nxh4, nyh4;
  logic [50:0]        nmag4, mmag4;
  logic [25:0]        pmag4, qmag4;
  logic               ns4, ms4, xs4, ys4;
  logic signed [26:0] p4, q4;
  logic [22:0]        zd4;
  logic [45:0]        zz4;
  logic               inv4, last4;

  always_ff @(posedge clk) begin
    if (en) begin
      nxl4  <= nmag3[25:0] * xmag3;
      nxh4  <= nmag3[50:26] * xmag3;
      nyl4  <= nmag3[25:0] * ymag3;
      nyh4  <= nmag3[50:26] * ymag3;
      nmag4 <= nmag3;
      mmag4 <= mmag3;
      pmag4 <= pmag3;
      qmag4 <= qmag3;
      ns4   <= n3[51];
      ms4   <= m3[51];
      xs4   <= x3[23];
      ys4   <= y3[23];
      p4    <= p3;
      q4    <= q3;
      zd4   <= z3[22:0];
      zz4   <= zz3;
      inv4  <= inv3;
      last4 <= last3;
    end
  end

  // Stage 5: join the partial products and settle the sign of each quotient.
  logic [74:0]        nx5, ny5;
  logic [50:0]        nmag5, mmag5;
  logic [25:0]        pmag5, qmag5;
  logic [22:0]        zd5;
  logic [45:0]        zz5;
  pjr_pkg::side_t     side5;

  always_ff @(posedge clk) begin
    if (en) begin
      nx5        <= {nxh4, 26'b0} + 75'(nxl4);
      ny5        <= {nyh4, 26'b0} + 75'(nyl4);
      nmag5      <= nmag4;
      mmag5      <= mmag4;
      pmag5      <= pmag4;
      qmag5      <= qmag4;
      zd5        <= zd4;
      zz5        <= zz4;
      // Quotient signs: tx, ty, tz (-N), rx (-N*Y), ry (N*X), rz (M).
      side5.neg  <= {ms4, ns4 ^ xs4, !ns4 ^ ys4, !ns4, q4[26], p4[26]};
      side5.p    <= p4;
      side5.q    <= q4;
      side5.inv  <= inv4;
      side5.last <= last4;
    end
  end

  // Six long dividers, all in lockstep.
  logic [QB:0] quo [0:5];

  pjr_divider #(.NUM_W(pjr_pkg::NUM_W_P), .DEN_W(pjr_pkg::DEN_W_Z)) u_div_tx (
    .clk(clk), .en(en), .num({pmag5, 28'b0}), .den(zd5), .quo(quo[0]));
  pjr_divider #(.NUM_W(pjr_pkg::NUM_W_P), .DEN_W(pjr_pkg::DEN_W_Z)) u_div_ty (
    .clk(clk), .en(en), .num({qmag5, 28'b0}), .den(zd5), .quo(quo[1]));
  pjr_divider #(.NUM_W(pjr_pkg::NUM_W_N), .DEN_W(pjr_pkg::DEN_W_ZZ)) u_div_tz (
    .clk(clk), .en(en), .num({nmag5, 28'b0}), .den(zz5), .quo(quo[2]));
  pjr_divider #(.NUM_W(pjr_pkg::NUM_W_NC), .DEN_W(pjr_pkg::DEN_W_ZZ)) u_div_rx (
    .clk(clk), .en(en), .num({ny5, 12'b0}), .den(zz5), .quo(quo[3]));
  pjr_divider #(.NUM_W(pjr_pkg::NUM_W_NC), .DEN_W(pjr_pkg::DEN_W_ZZ)) u_div_ry (
    .clk(clk), .en(en), .num({nx5, 12'b0}), .den(zz5), .quo(quo[4]));
  pjr_divider #(.NUM_W(pjr_pkg::NUM_W_M), .DEN_W(pjr_pkg::DEN_W_Z)) u_div_rz (
    .clk(clk), .en(en), .num({mmag5, 12'b0}), .den(zd5), .quo(quo[5]));

  // Side information travels beside the dividers.
  pjr_pkg::side_t dly [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      dly[0] <= side5;
      for (int i = 1; i < DIV_LAT; i++) begin
        dly[i] <= dly[i-1];
      end
    end
  end

  // Stage 6: apply the signs, add the P term to ry and subtract the Q term from rx.
  logic signed [49:0] sq [0:5];
  pjr_pkg::side_t     side_d;

  assign side_d = dly[DIV_LAT-1];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      sq[k] = side_d.neg[k] ? -$signed({1'b0, quo[k]}) : $signed({1'b0, quo[k]});
    end
  end

  logic signed [50:0] v6 [0:5];
  logic               inv6, last6;

  always_ff @(posedge clk) begin
    if (en) begin
      v6[0] <= 51'(sq[0]);
      v6[1] <= 51'(sq[1]);
      v6[2] <= 51'(sq[2]);
      v6[3] <= 51'(sq[3]) - (51'(side_d.q) <<< 12);
      v6[4] <= 51'(sq[4]) + (51'(side_d.p) <<< 12);
      v6[5] <= 51'(sq[5]);
      inv6  <= side_d.inv;
      last6 <= side_d.last;
    end
  end

  // Stage 7: clamp to 48 bits; a point with zero or negative depth gives zeros.
  localparam logic signed [50:0] OUT_MAX = 51'sd140737488355327;
  localparam logic signed [50:0] OUT_MIN = -51'sd140737488355328;

  logic [47:0] cl [0:5];
  logic [5:0]  cl_sat;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      if (v6[k] > OUT_MAX) begin
        cl[k]     = OUT_MAX[47:0];
        cl_sat[k] = 1'b1;
      end else if (v6[k] < OUT_MIN) begin
        cl[k]     = OUT_MIN[47:0];
        cl_sat[k] = 1'b1;
      end else begin
        cl[k]     = v6[k][47:0];
        cl_sat[k] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (inv6) begin
        m_tdata <= '0;
        m_tuser <= 2'b01;
      end else begin
        m_tdata <= {cl[5], cl[4], cl[3], cl[2], cl[1], cl[0]};
        m_tuser <= {|cl_sat, 1'b0};
      end
      m_tlast <= last6;
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1     <= 1'b0;
      vld2     <= 1'b0;
      vld3     <= 1'b0;
      vld4     <= 1'b0;
      vld5     <= 1'b0;
      vld6     <= 1'b0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < DIV_LAT; i++) begin
        dly_v[i] <= 1'b0;
      end
    end else if (en) begin
      vld1     <= s_tvalid;
      vld2     <= vld1;
      vld3     <= vld2;
      vld4     <= vld3;
      vld5     <= vld4;
      dly_v[0] <= vld5;
      for (int i = 1; i < DIV_LAT; i++) begin
        dly_v[i] <= dly_v[i-1];
      end
      vld6     <= dly_v[DIV_LAT-1];
      m_tvalid <= vld6;
    end
  end

  // A saturated result must hold at least one entry at a range limit.
  logic any_limit;
  always_comb begin
    any_limit = 1'b0;
    for (int k = 0; k < 6; k++) begin
      if (m_tdata[k*48 +: 48] == OUT_MAX[47:0] || m_tdata[k*48 +: 48] == OUT_MIN[47:0]) begin
        any_limit = 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> !m_tuser[1] && m_tdata == '0)
    else $error("invalid depth result is not all zero");

  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> any_limit)
    else $error("saturated flag without a clamped entry");

  a_cfg_fx: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_index == pjr_pkg::REG_FOCAL_X |=> focal_x == $past(cfg_data))
    else $error("focal_x write lost");
`endif

endmodule

@@ tb/sv/pjr_checker.sv @@
`timescale 1ns / 1ps

module pjr_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [95:0]  s_tdata,
  input  logic         s_tlast,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [287:0] m_tdata,
  input  logic [1:0]   m_tuser,
  input  logic         m_tlast,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [pjr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pjr_pkg::FOCAL_W-1:0]     cfg_data,
  output int           errors,
  output int           pending
);

  typedef struct packed {
    logic [5:0][pjr_pkg::JAC_W-1:0] jac;
    logic                           depth_bad;
    logic                           clamped;
    logic                           last;
  } row_t;

  localparam logic signed [127:0] ENTRY_MAX = (128'sd1 <<< 47) - 1;
  localparam logic signed [127:0] ENTRY_MIN = -(128'sd1 <<< 47);
  localparam logic [159:0] QUO_CAP = 160'd1 << 62;

  logic [pjr_pkg::FOCAL_W-1:0] fx, fy;
  row_t rows_due[$];

  assign pending = rows_due.size();

  // Truncated num * 2^sh / den, magnitude held at 2^62; the divider holds at 2^QUO_BITS.
  function automatic logic signed [127:0] scaled_quotient(logic signed [127:0] num, int sh,
                                                           logic signed [127:0] den);
    logic [159:0] wide;
    logic [159:0] quo;
    logic signed [127:0] res;
    wide = (num < 0) ? 160'(-num) : 160'(num);
    wide = wide << sh;
    quo = wide / 160'(den);
    if (quo > QUO_CAP) quo = QUO_CAP;
    res = 128'(quo);
    return (num < 0) ? -res : res;
  endfunction

  function automatic row_t jacobian_row(logic [95:0] d, logic lst);
    logic signed [127:0] gx, gy, x, y, z, p, q, n, zz;
    logic signed [127:0] v [6];
    row_t r;
    gx = 128'(signed'(d[10:0]));
    gy = 128'(signed'(d[21:11]));
    x  = 128'(signed'(d[45:22]));
    y  = 128'(signed'(d[69:46]));
    z  = 128'(signed'(d[93:70]));
    r = '0;
    r.last = lst;
    if (z <= 0) begin
      r.depth_bad = 1'b1;
      return r;
    end
    zz = z * z;
    p = gx * $signed({112'd0, fx});
    q = gy * $signed({112'd0, fy});
    n = p * x + q * y;
    v[0] = scaled_quotient(p, 28, z);
    v[1] = scaled_quotient(q, 28, z);
    v[2] = scaled_quotient(-n, 28, zz);
    v[3] = scaled_quotient(-n * y, 12, zz) - q * 4096;
    v[4] = p * 4096 + scaled_quotient(n * x, 12, zz);
    v[5] = scaled_quotient(q * x - p * y, 12, z);
    for (int i = 0; i < 6; i++) begin
      if (v[i] > ENTRY_MAX) begin
        v[i] = ENTRY_MAX;
        r.clamped = 1'b1;
      end else if (v[i] < ENTRY_MIN) begin
        v[i] = ENTRY_MIN;
        r.clamped = 1'b1;
      end
      r.jac[i] = v[i][pjr_pkg::JAC_W-1:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    row_t want, got;
    if (rst) begin
      fx <= pjr_pkg::FOCAL_RESET;
      fy <= pjr_pkg::FOCAL_RESET;
      errors <= 0;
      rows_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == pjr_pkg::REG_FOCAL_X) fx <= cfg_data;
        else if (cfg_index == pjr_pkg::REG_FOCAL_Y) fy <= cfg_data;
      end
      if (s_tvalid && s_tready)
        rows_due.insert(rows_due.size(), jacobian_row(s_tdata, s_tlast));
      if (m_tvalid && m_tready) begin
        got.jac = m_tdata;
        got.depth_bad = m_tuser[0];
        got.clamped = m_tuser[1];
        got.last = m_tlast;
        if (rows_due.size() == 0) begin
          $error("unexpected result row %h", m_tdata);
          errors <= errors + 1;
        end else begin
          want = rows_due.pop_front();
          if (want !== got) errors <= errors + 1;
          for (int i = 0; i < 6; i++)
            if (want.jac[i] !== got.jac[i])
              $error("jac[%0d]: expected %h, got %h", i, want.jac[i], got.jac[i]);
          if (want.depth_bad !== got.depth_bad)
            $error("depth_invalid: expected %b, got %b", want.depth_bad, got.depth_bad);
          if (want.clamped !== got.clamped)
            $error("saturated: expected %b, got %b", want.clamped, got.clamped);
          if (want.last !== got.last)
            $error("last_result: expected %b, got %b", want.last, got.last);
        end
      end
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  // An index past the last register; the block must ignore a write to it.
  localparam logic [pjr_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 8'd2;
  localparam int PIPE_CYCLES = 70;     // pipeline depth plus margin
  localparam int IDLE_LIMIT  = 5000;   // well above the longest legal quiet stretch
  localparam int LONG_HOLD   = 400;    // receiver back-pressure long enough to fill the pipe
  localparam int RANDOM_POINTS = 1750;

  localparam logic [pjr_pkg::FOCAL_W-1:0] FXS [5] =
    '{16'd0, 16'd65535, 16'd8192, 16'd16, 16'd0};
  localparam logic [pjr_pkg::FOCAL_W-1:0] FYS [5] =
    '{16'd0, 16'd65535, 16'd1000, 16'd65535, 16'd0};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [95:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [287:0] m_tdata;
  logic [1:0] m_tuser;
  logic m_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [pjr_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [pjr_pkg::FOCAL_W-1:0] cfg_data = '0;
  int errors, pending;
  int quiet = 0;
  int results_seen = 0;

  always #5 clk = ~clk;

  photometric_jacobian_row DUT (.*);

  pjr_checker checker_i (.*);

  // Watchdog: a run that stops moving is a failure.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: random hold-offs per result, calm stretches, and one long hold
  // while the sender keeps offering requests so that s_tready must drop.
  initial begin
    int hold;
    bool_loop: forever begin
      if (results_seen == 300) hold = LONG_HOLD;
      else if ((results_seen / 100) % 3 == 1) hold = 0;
      else hold = $urandom_range(0, 16);
      if (hold > 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(negedge clk); while (!m_tvalid);
      @(posedge clk);
      results_seen++;
    end
  end

  task automatic write_reg(logic [pjr_pkg::CFG_INDEX_W-1:0] idx,
                           logic [pjr_pkg::FOCAL_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Registers change only with the pipeline empty.
  task automatic drain;
    while (pending != 0) @(posedge clk);
    repeat (PIPE_CYCLES) @(posedge clk);
  endtask

  task automatic send_point(logic signed [10:0] gx, logic signed [10:0] gy,
                            logic signed [23:0] x, logic signed [23:0] y,
                            logic signed [23:0] z, logic lst, bit calm);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, z, y, x, gy, gx};
    s_tlast <= lst;
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
  endtask

  task automatic end_burst;
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Random point: mostly plausible depths and coordinates so that entries stay
  // in range, with some raw full-range values mixed in.
  task automatic random_point(bit calm);
    logic signed [23:0] x, y, z;
    int shape;
    shape = $urandom_range(0, 9);
    if (shape < 6) begin
      z = 24'($urandom_range(1 << 12, 1 << 22));
      x = 24'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
      y = 24'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
    end else if (shape < 8) begin
      z = 24'($urandom_range(1, 1 << 23));
      x = 24'($urandom);
      y = 24'($urandom);
    end else begin
      z = 24'($urandom);
      x = 24'($urandom);
      y = 24'($urandom);
    end
    send_point(11'(int'($urandom_range(0, 2040)) - 1020),
               11'(int'($urandom_range(0, 2040)) - 1020),
               x, y, z, 1'($urandom_range(0, 7) == 0), calm);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed points at reset focal lengths.
    send_point(11'sd1020, 11'sd1020, 24'sd65536, 24'sd65536, 24'sd65536, 1'b0, 1'b1);
    send_point(-11'sd1020, -11'sd1020, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 1'b0, 1'b1);
    send_point(11'sd5, -11'sd7, 24'sd1000, 24'sd2000, 24'sd0, 1'b0, 1'b1);        // zero depth
    send_point(11'sd5, -11'sd7, 24'sd1000, 24'sd2000, 24'h800000, 1'b1, 1'b1);    // negative depth
    send_point(11'sd1020, -11'sd1020, 24'h7FFFFF, 24'h7FFFFF, 24'sd1, 1'b0, 1'b0); // tiny depth
    send_point(11'sd0, 11'sd0, 24'h800000, 24'h7FFFFF, 24'sd1, 1'b0, 1'b0);
    send_point(-11'sd1020, 11'sd1020, 24'h800000, 24'h800000, 24'sd256, 1'b0, 1'b0);
    send_point(11'sd1, 11'sd1, 24'sd0, 24'sd0, 24'h7FFFFF, 1'b1, 1'b0);
    send_point(-11'sd1, 11'sd300, -24'sd65536, 24'sd32768, 24'sd131072, 1'b0, 1'b0);
    end_burst();
    drain();

    // Ignored write, then each setting in turn including the extremes.
    write_reg(REG_UNUSED, 16'd1234);
    send_point(11'sd100, 11'sd100, 24'sd65536, 24'sd65536, 24'sd65536, 1'b1, 1'b1);
    end_burst();
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      if (ph < 5) begin
        write_reg(pjr_pkg::REG_FOCAL_X, FXS[ph]);
        write_reg(pjr_pkg::REG_FOCAL_Y, FYS[ph]);
      end else begin
        write_reg(pjr_pkg::REG_FOCAL_X, 16'($urandom));
        write_reg(pjr_pkg::REG_FOCAL_Y, 16'($urandom));
      end
      if (ph == 0) begin
        send_point(11'sd1020, 11'sd1020, 24'sd1, 24'sd1, 24'sd1, 1'b1, 1'b1);
        end_burst();
      end else begin
        for (int k = 0; k < RANDOM_POINTS / 5; k++)
          random_point(((k / 50) % 3) == 2);
        end_burst();
      end
    end

    drain();
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/pjr_pkg.sv
rtl/pjr_divider.sv
rtl/photometric_jacobian_row.sv
tb/sv/pjr_checker.sv
tb/sv/tb_top.sv
